@@ design/tcgr_pkg.sv @@
// Shared types, codes and helpers for the text console glyph renderer.
package tcgr_pkg;

  // Glyph cell width in pixels and font store geometry.
  localparam int unsigned GlyphW    = 8;
  localparam int unsigned FontDepth = 4096;
  localparam int unsigned FontAw    = 12;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_SET_POS  = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_LOAD_FNT = 2'd3
  } tcgr_op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_CURSOR = 2'd2
  } tcgr_kind_e;

  // Control characters that move the cursor instead of drawing.
  localparam logic [7:0] ChrLf  = 8'd10;
  localparam logic [7:0] ChrCr  = 8'd13;
  localparam logic [7:0] ChrTab = 8'd9;

  // Reset value of the text colour register.
  localparam logic [7:0] ColourReset = 8'd15;

  // Input item payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [6:0]  new_col;
    logic [5:0]  new_row;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
  } tcgr_in_t;

  // Result item payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [63:0] row_colours;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        last;
  } tcgr_out_t;

  // Expand one font byte into eight colours, leftmost pixel in the top byte.
  function automatic logic [63:0] expand_row(logic [7:0] bits, logic [7:0] colour);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc[63 - 8*i -: 8] = bits[7 - i] ? colour : 8'd0;
    end
    return acc;
  endfunction

endpackage

@@ design/text_console_glyph_renderer.sv @@
// Text console cursor tracker and 8-pixel-wide glyph row generator.
//
// Usage: input items arrive on in_valid_i/in_ready_o with an opcode that
// puts a character, sets the cursor, clears the screen or loads one font
// byte. Results leave on out_valid_o/out_ready_i through an output register.
// The user writes the text colour register through cfg_we_i/cfg_data_i only
// while idle; the block itself does not enforce this. A font load gives no
// result. Set position, clear and the control characters (line feed, carriage
// return, tab) give one result, registered in the output register once it is
// free. A printable character gives GLYPH_H glyph rows, each read through the
// font RAM read register and then the output register, one per cycle while
// the receiver does not stall. The cursor is
// updated as the item is accepted; every result of an item reports the new
// cursor. Input is not taken while an item's results are still being
// produced, but the next item is taken while the last result waits in the
// output register. A stall on the output simply pauses the row sequencer; no
// result is lost. Reset homes the cursor, sets the text colour to 15 and
// empties the output register. The font RAM is not cleared and must be
// loaded before drawing.
module text_console_glyph_renderer #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480,
  parameter int unsigned GLYPH_H  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcgr_pkg::tcgr_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcgr_pkg::tcgr_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i
);

  import tcgr_pkg::*;

  // Text grid size, capped to what the cursor registers hold.
  localparam int unsigned RawCols  = SCREEN_W / GlyphW;
  localparam int unsigned RawRows  = SCREEN_H / GLYPH_H;
  localparam int unsigned TextCols = (RawCols > 128) ? 128 : RawCols;
  localparam int unsigned TextRows = (RawRows > 32) ? 32 : RawRows;
  localparam logic [7:0]  ColLimit = 8'(TextCols);
  localparam logic [5:0]  RowLimit = 6'(TextRows);
  localparam logic [4:0]  RowLast  = 5'(TextRows - 1);

  // Glyph row counter geometry.
  localparam int unsigned RowW     = $clog2(GLYPH_H);
  localparam logic [RowW-1:0] RowEnd = RowW'(GLYPH_H - 1);
  localparam logic [FontAw-1:0] AddrStep = FontAw'(GLYPH_H);
  localparam logic [8:0]  PyStep   = 9'(GLYPH_H);

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_REPORT = 3'b010,
    ST_GLYPH  = 3'b100
  } tcgr_state_e;

  tcgr_state_e state_q, state_d;

  logic [7:0]        colour_q;
  logic [6:0]        col_q, col_d;
  logic [4:0]        line_q, line_d;
  logic [1:0]        rep_kind_q, rep_kind_d;
  logic              out_valid_q, out_valid_d;
  tcgr_out_t         out_q, out_d;

  logic [FontAw-1:0] addr_q, addr_d;
  logic [9:0]        px_q, px_d;
  logic [8:0]        py_q, py_d;
  logic [RowW-1:0]   rd_idx_q, rd_idx_d;
  logic [RowW-1:0]   em_idx_q, em_idx_d;
  logic              rd_all_q, rd_all_d;
  logic              rd_pend_q, rd_pend_d;

  logic              in_acc;
  logic              out_free;
  logic              rd_issue;
  logic              load_row;
  logic              printable;
  logic [7:0]        col_inc;
  logic [7:0]        col_tab;
  logic [5:0]        line_inc;
  logic [6:0]        mv_col;
  logic [5:0]        mv_line;
  logic [7:0]        font_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign printable  = (in_data_i.char_code != ChrLf) && (in_data_i.char_code != ChrCr) &&
                      (in_data_i.char_code != ChrTab);

  // Glyph row reads run one ahead of the output register.
  assign load_row = (state_q == ST_GLYPH) && rd_pend_q && out_free;
  assign rd_issue = (state_q == ST_GLYPH) && !rd_all_q && (!rd_pend_q || load_row);

  // Font store.
  tcgr_ram #(
    .Width (8),
    .Depth (FontDepth)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_data_i.opcode == OP_LOAD_FNT)),
    .waddr_i (in_data_i.font_address),
    .wdata_i (in_data_i.font_byte),
    .re_i    (rd_issue),
    .raddr_i (addr_q),
    .rdata_o (font_rdata)
  );

  // Cursor movement for the put opcode, before the row clamp.
  always_comb begin
    col_inc  = {1'b0, col_q} + 8'd1;
    col_tab  = ({1'b0, col_q} + 8'd4) & ~8'd3;
    line_inc = {1'b0, line_q} + 6'd1;
    mv_col   = col_q;
    mv_line  = {1'b0, line_q};
    if (in_data_i.char_code == ChrLf) begin
      mv_col  = '0;
      mv_line = line_inc;
    end else if (in_data_i.char_code == ChrCr) begin
      mv_col = '0;
    end else if (in_data_i.char_code == ChrTab) begin
      if (col_tab >= ColLimit) begin
        mv_col  = '0;
        mv_line = line_inc;
      end else begin
        mv_col = col_tab[6:0];
      end
    end else if (col_inc >= ColLimit) begin
      mv_col  = '0;
      mv_line = line_inc;
    end else begin
      mv_col = col_inc[6:0];
    end
  end

  // Sequencer, cursor and output register next state.
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    line_d      = line_q;
    rep_kind_d  = rep_kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    addr_d      = addr_q;
    px_d        = px_q;
    py_d        = py_q;
    rd_idx_d    = rd_idx_q;
    em_idx_d    = em_idx_q;
    rd_all_d    = rd_all_q;
    rd_pend_d   = rd_pend_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            OP_CLEAR: begin
              col_d      = '0;
              line_d     = '0;
              rep_kind_d = KIND_CLEAR;
              state_d    = ST_REPORT;
            end
            OP_SET_POS: begin
              if ({1'b0, in_data_i.new_col} < ColLimit) begin
                col_d = in_data_i.new_col;
              end
              if (in_data_i.new_row < RowLimit) begin
                line_d = in_data_i.new_row[4:0];
              end
              rep_kind_d = KIND_CURSOR;
              state_d    = ST_REPORT;
            end
            OP_PUT_CHAR: begin
              col_d  = mv_col;
              line_d = (mv_line >= RowLimit) ? RowLast : mv_line[4:0];
              if (printable) begin
                addr_d    = FontAw'(FontAw'(in_data_i.char_code) * AddrStep);
                px_d      = {col_q, 3'b000};
                py_d      = 9'(9'(line_q) * PyStep);
                rd_idx_d  = '0;
                em_idx_d  = '0;
                rd_all_d  = 1'b0;
                rd_pend_d = 1'b0;
                state_d   = ST_GLYPH;
              end else begin
                rep_kind_d = KIND_CURSOR;
                state_d    = ST_REPORT;
              end
            end
            default: begin
              // Font load writes the RAM and gives no result.
            end
          endcase
        end
      end

      ST_REPORT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.kind         = rep_kind_q;
          out_d.pixel_x      = '0;
          out_d.pixel_y      = '0;
          out_d.row_colours  = '0;
          out_d.cursor_col   = col_q;
          out_d.cursor_row   = line_q;
          out_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end

      ST_GLYPH: begin
        if (rd_issue) begin
          addr_d    = addr_q + FontAw'(1);
          rd_idx_d  = rd_idx_q + RowW'(1);
          rd_all_d  = (rd_idx_q == RowEnd);
          rd_pend_d = 1'b1;
        end else if (load_row) begin
          rd_pend_d = 1'b0;
        end
        if (load_row) begin
          out_valid_d        = 1'b1;
          out_d.kind         = KIND_GLYPH;
          out_d.pixel_x      = px_q;
          out_d.pixel_y      = py_q;
          out_d.row_colours  = expand_row(font_rdata, colour_q);
          out_d.cursor_col   = col_q;
          out_d.cursor_row   = line_q;
          out_d.last         = (em_idx_q == RowEnd);
          py_d               = py_q + 9'd1;
          em_idx_d           = em_idx_q + RowW'(1);
          if (em_idx_q == RowEnd) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      colour_q    <= ColourReset;
      col_q       <= '0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
      rd_all_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
      rd_all_q    <= rd_all_d;
      rd_pend_q   <= rd_pend_d;
      if (cfg_we_i) begin
        colour_q <= cfg_data_i;
      end
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk_i) begin
    rep_kind_q <= rep_kind_d;
    out_q      <= out_d;
    addr_q     <= addr_d;
    px_q       <= px_d;
    py_q       <= py_d;
    rd_idx_q   <= rd_idx_d;
    em_idx_q   <= em_idx_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/tcgr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/tcgr_glyph_checker.sv @@
// Checker for the text console glyph renderer: cursor and glyph prediction, result comparison.
module tcgr_glyph_checker #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480,
  parameter int unsigned GLYPH_H  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tcgr_pkg::tcgr_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tcgr_pkg::tcgr_out_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  output int                  mismatches_o,
  output int                  backlog_o,
  output int                  items_o,
  output int                  results_o,
  output int                  glyph_rows_o
);

  import tcgr_pkg::*;

  // Text grid, capped to what the cursor registers can hold.
  localparam int RawCols  = int'(SCREEN_W / GlyphW);
  localparam int RawRows  = int'(SCREEN_H / GLYPH_H);
  localparam int TextCols = (RawCols > 128) ? 128 : RawCols;
  localparam int TextRows = (RawRows > 32) ? 32 : RawRows;

  logic [7:0] glyph_rom [FontDepth];
  logic [7:0] fg_colour;
  int         col_pos;
  int         line_pos;
  tcgr_out_t  pending_rows [$];
  tcgr_out_t  want_row;
  int         mismatches;
  int         item_count;
  int         result_count;
  int         glyph_row_count;

  assign mismatches_o = mismatches;
  assign items_o      = item_count;
  assign results_o    = result_count;
  assign glyph_rows_o = glyph_row_count;

  // Turn one font byte into eight pixel colours, leftmost pixel in the top byte.
  function automatic logic [63:0] paint_row(logic [7:0] bits);
    logic [63:0] acc;
    acc = '0;
    for (int b = 0; b < 8; b++) begin
      if (bits[7 - b]) begin
        acc[63 - 8*b -: 8] = fg_colour;
      end
    end
    return acc;
  endfunction

  // A single-result item: no pixels, just the cursor after the item.
  function automatic tcgr_out_t cursor_result(tcgr_kind_e k);
    tcgr_out_t r;
    r = '0;
    r.kind       = k;
    r.cursor_col = col_pos[6:0];
    r.cursor_row = line_pos[4:0];
    r.last       = 1'b1;
    return r;
  endfunction

  // Apply one accepted item to the cursor and font state and queue its results.
  task automatic predict_item(tcgr_in_t it);
    logic [63:0] painted [GLYPH_H];
    tcgr_out_t   r;
    int          px;
    int          py;
    int          base;
    bit          drew;
    drew = 1'b0;
    px   = 0;
    py   = 0;
    case (it.opcode)
      OP_LOAD_FNT: begin
        glyph_rom[it.font_address] = it.font_byte;
      end
      OP_CLEAR: begin
        col_pos  = 0;
        line_pos = 0;
        pending_rows.push_back(cursor_result(KIND_CLEAR));
      end
      OP_SET_POS: begin
        // Each coordinate is taken only when it lies on the grid.
        if (int'(it.new_col) < TextCols) col_pos = it.new_col;
        if (int'(it.new_row) < TextRows) line_pos = it.new_row;
        pending_rows.push_back(cursor_result(KIND_CURSOR));
      end
      default: begin
        if (it.char_code == ChrLf) begin
          col_pos = 0;
          line_pos++;
        end else if (it.char_code == ChrCr) begin
          col_pos = 0;
        end else if (it.char_code == ChrTab) begin
          col_pos = (col_pos + 4) & ~3;
          if (col_pos >= TextCols) begin
            col_pos = 0;
            line_pos++;
          end
        end else begin
          // Printable: read the glyph at the old cursor, then advance.
          drew = 1'b1;
          px   = col_pos * GlyphW;
          py   = line_pos * GLYPH_H;
          base = int'(it.char_code) * GLYPH_H;
          for (int g = 0; g < GLYPH_H; g++) begin
            painted[g] = paint_row(glyph_rom[(base + g) % FontDepth]);
          end
          col_pos++;
          if (col_pos >= TextCols) begin
            col_pos = 0;
            line_pos++;
          end
        end
        // No scrolling: the cursor sticks on the bottom line.
        if (line_pos >= TextRows) line_pos = TextRows - 1;
        if (drew) begin
          for (int g = 0; g < GLYPH_H; g++) begin
            r             = cursor_result(KIND_GLYPH);
            r.pixel_x     = px[9:0];
            r.pixel_y     = 9'(py + g);
            r.row_colours = painted[g];
            r.last        = (g == GLYPH_H - 1);
            pending_rows.push_back(r);
          end
        end else begin
          pending_rows.push_back(cursor_result(KIND_CURSOR));
        end
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: result %0d field %s expected %0h actual %0h",
               $time, result_count, name, want, got);
      mismatches++;
    end
  endtask

  // Follow both channels and the colour register at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_colour       = ColourReset;
      col_pos         = 0;
      line_pos        = 0;
      pending_rows.delete();
      mismatches      = 0;
      item_count      = 0;
      result_count    = 0;
      glyph_row_count = 0;
      backlog_o       = 0;
    end else begin
      // Results are matched first; a result never comes out on the edge its item enters.
      if (out_valid_i && out_ready_i) begin
        result_count++;
        if (pending_rows.size() == 0) begin
          $display("%0t: result %0d expected none actual %0h",
                   $time, result_count, out_data_i);
          mismatches++;
        end else begin
          want_row = pending_rows.pop_front();
          if (want_row.kind == KIND_GLYPH) glyph_row_count++;
          compare_field("kind", want_row.kind, out_data_i.kind);
          compare_field("pixel_x", want_row.pixel_x, out_data_i.pixel_x);
          compare_field("pixel_y", want_row.pixel_y, out_data_i.pixel_y);
          compare_field("row_colours", want_row.row_colours, out_data_i.row_colours);
          compare_field("cursor_col", want_row.cursor_col, out_data_i.cursor_col);
          compare_field("cursor_row", want_row.cursor_row, out_data_i.cursor_row);
          compare_field("last", want_row.last, out_data_i.last);
        end
      end
      if (cfg_we_i) fg_colour = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        item_count++;
        predict_item(in_data_i);
      end
      backlog_o = pending_rows.size();
    end
  end

endmodule

@@ bench/tb_text_console_glyph_renderer.sv @@
// Testbench top for the text console glyph renderer: stimulus, idling and verdict.
module tb_text_console_glyph_renderer;
  import tcgr_pkg::*;

  localparam int unsigned ScreenW = 640;
  localparam int unsigned ScreenH = 480;
  localparam int unsigned GlyphH  = 16;
  localparam int TextCols      = (int'(ScreenW / GlyphW) > 128) ? 128 : int'(ScreenW / GlyphW);
  localparam int TextRows      = (int'(ScreenH / GlyphH) > 32) ? 32 : int'(ScreenH / GlyphH);
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 24;
  localparam int SettleCycles  = 4;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  tcgr_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  tcgr_out_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_data;

  int mismatches;
  int backlog;
  int items_seen;
  int results_seen;
  int glyph_rows_seen;

  // One in N chance of an idle burst per opportunity; zero turns idling off.
  int gap_odds;
  int stall_odds;

  // Characters whose whole glyph is loaded.
  bit         is_drawable [256];
  logic [7:0] drawable [$];

  text_console_glyph_renderer #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH),
    .GLYPH_H (GlyphH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  tcgr_glyph_checker #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH),
    .GLYPH_H (GlyphH)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .backlog_o   (backlog),
    .items_o     (items_seen),
    .results_o   (results_seen),
    .glyph_rows_o(glyph_rows_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stall bursts.
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        hold = $urandom_range(1, 5);
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Random filler in every field, then the wanted operation.
  function automatic tcgr_in_t noise_item(tcgr_op_e op);
    logic [63:0] raw;
    tcgr_in_t    it;
    raw       = {$urandom(), $urandom()};
    it        = raw[$bits(tcgr_in_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  // Present one item, possibly after an idle burst, and hold it until taken.
  task automatic send(tcgr_in_t it);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic load_byte(int addr, logic [7:0] val);
    tcgr_in_t it;
    it              = noise_item(OP_LOAD_FNT);
    it.font_address = 12'(addr);
    it.font_byte    = val;
    send(it);
  endtask

  // Load a whole glyph; the first two rows are all clear and all set.
  task automatic load_glyph(logic [7:0] ch);
    logic [7:0] val;
    for (int g = 0; g < GlyphH; g++) begin
      if (g == 0) val = 8'h00;
      else if (g == 1) val = 8'hFF;
      else val = 8'($urandom());
      load_byte(int'(ch) * GlyphH + g, val);
    end
    if (!is_drawable[ch]) begin
      is_drawable[ch] = 1'b1;
      drawable.push_back(ch);
    end
  endtask

  task automatic put(logic [7:0] ch);
    tcgr_in_t it;
    it           = noise_item(OP_PUT_CHAR);
    it.char_code = ch;
    send(it);
  endtask

  task automatic set_pos(int col, int row);
    tcgr_in_t it;
    it         = noise_item(OP_SET_POS);
    it.new_col = 7'(col);
    it.new_row = 6'(row);
    send(it);
  endtask

  task automatic clear_home();
    send(noise_item(OP_CLEAR));
  endtask

  // Let every expected result drain and the block go idle, then set the colour.
  task automatic recolour(logic [7:0] colour);
    while (backlog != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = colour;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Mostly drawable text and cursor moves, with some font noise in between.
  task automatic random_phase(int budget);
    int sent;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        load_glyph(8'($urandom_range(0, 255)));
        sent += GlyphH;
      end else begin
        if (pick < 55) begin
          put(drawable[$urandom_range(0, drawable.size() - 1)]);
        end else if (pick < 65) begin
          case ($urandom_range(0, 2))
            0: put(ChrLf);
            1: put(ChrCr);
            default: put(ChrTab);
          endcase
        end else if (pick < 80) begin
          case ($urandom_range(0, 2))
            0: set_pos($urandom_range(0, TextCols - 1), $urandom_range(0, TextRows - 1));
            // Near the right and bottom edges, where wrap and clamp happen.
            1: set_pos($urandom_range(TextCols - 6, TextCols - 1),
                       $urandom_range(TextRows - 3, TextRows - 1));
            default: set_pos($urandom_range(0, 127), $urandom_range(0, 63));
          endcase
        end else if (pick < 85) begin
          clear_home();
        end else begin
          load_byte($urandom_range(0, FontDepth - 1), 8'($urandom()));
        end
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    gap_odds   = 0;
    stall_odds = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Glyphs for the lowest and highest character codes.
    load_glyph(8'h00);
    load_glyph(8'hFF);

    // Directed cases with the reset colour.
    gap_odds   = 4;
    stall_odds = 4;
    put(8'h00);
    put(8'hFF);
    set_pos(TextCols - 1, TextRows - 1);
    put(8'hFF);
    put(ChrLf);
    set_pos(40, TextRows - 1);
    put(ChrCr);
    put(ChrTab);
    set_pos(75, 5);
    put(ChrTab);
    put(ChrTab);
    set_pos(77, 7);
    put(ChrTab);
    set_pos(127, 63);
    set_pos(100, 3);
    set_pos(10, 40);
    set_pos(TextCols, TextRows);
    set_pos(TextCols - 1, 10);
    put(8'h00);
    clear_home();

    // Random phases over several colours, the extremes first.
    recolour(8'hFF);
    gap_odds   = 3;
    stall_odds = 5;
    random_phase(45);
    recolour(8'h00);
    gap_odds   = 2;
    stall_odds = 2;
    random_phase(40);
    recolour(8'($urandom()));
    gap_odds   = 0;
    stall_odds = 0;
    random_phase(30);
    recolour(8'($urandom()));
    gap_odds   = 6;
    stall_odds = 3;
    random_phase(40);
    // Last stretch at full rate on both sides.
    recolour(8'($urandom()));
    gap_odds   = 0;
    stall_odds = 0;
    random_phase(25);

    while (backlog != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d items and checked %0d results, %0d of them glyph rows,",
             items_seen, results_seen, glyph_rows_seen);
    $display("over six text colour settings with %0d drawable characters.", drawable.size());
    if (mismatches == 0 && backlog == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, backlog);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
